@@ rtl/word_frequency_tally_defines.svh @@
// Assertion macros for the word frequency tally RTL.
`ifndef WORD_FREQUENCY_TALLY_DEFINES_SVH
`define WORD_FREQUENCY_TALLY_DEFINES_SVH

// Same-cycle implication, clocked on aclk and disabled during reset.
`define WFT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("wft assertion failed");

// Next-cycle implication, clocked on aclk and disabled during reset.
`define WFT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("wft assertion failed");

`endif

@@ rtl/wft_pkg.sv @@
// Shared constants, types and helpers for the word frequency tally.
`timescale 1ns / 1ps
`default_nettype none
package wft_pkg;

    localparam int WORD_CHARS    = 64;
    localparam int TABLE_ENTRIES = 4096;

    localparam int WIDX_W  = (WORD_CHARS > 1) ? $clog2(WORD_CHARS) : 1;
    localparam int LEN_W   = $clog2(WORD_CHARS + 1);
    localparam int EIDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int USED_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int WB_DEPTH = 2 * WORD_CHARS;
    localparam int WB_W    = $clog2(WB_DEPTH);
    localparam int CH_DEPTH = TABLE_ENTRIES * WORD_CHARS;
    localparam int CADDR_W = (CH_DEPTH > 1) ? $clog2(CH_DEPTH) : 1;

    localparam int IDX_OUT_W = 12;
    localparam int COUNT_W   = 32;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        ST_COUNTED  = 2'd0,
        ST_INSERTED = 2'd1,
        ST_STOPPED  = 2'd2
    } tally_status_t;

    // Oldest finished word waiting in the front queue.
    typedef struct packed {
        logic             valid;
        logic             bank;
        logic [LEN_W-1:0] len;
    } word_desc_t;

    function automatic logic is_separator(input logic [7:0] b);
        return (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) ||
               (b == 8'h0D) || (b == 8'h0B) || (b == 8'h0C);
    endfunction

endpackage
`default_nettype wire

@@ rtl/word_frequency_tally.sv @@
// The wait for a result, for a new word or a repeated one, grows with the stored word length;
// each stored entry checked ahead of it adds to the wait, and so does each character compared in it.
// Throughput: one byte per cycle while fewer than two finished words wait for the search;
// the search over stored entries in the back end sets the sustained word rate.
// Reset (aresetn low, synchronous) empties the table and clears the stop flag; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module word_frequency_tally (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [7:0]                        s_text_byte,
    input  wire logic                              s_end_of_text,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [wft_pkg::IDX_OUT_W-1:0]          m_entry_index,
    output logic [wft_pkg::COUNT_W-1:0]            m_word_count,
    output logic [1:0]                             m_tally_status
);

    logic                       wb_we;
    logic [wft_pkg::WB_W-1:0]   wb_waddr, wb_raddr;
    logic [7:0]                 wb_wdata, wb_rdata;
    wft_pkg::word_desc_t        head;
    logic                       pop;

    // Two-bank word buffer shared by the front and back ends.
    wft_ram #(.WIDTH(8), .DEPTH(wft_pkg::WB_DEPTH)) u_word_buf (
        .aclk(aclk), .we(wb_we), .waddr(wb_waddr), .wdata(wb_wdata),
        .raddr(wb_raddr), .rdata(wb_rdata)
    );

    wft_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_text_byte(s_text_byte), .s_end_of_text(s_end_of_text),
        .wb_we(wb_we), .wb_waddr(wb_waddr), .wb_wdata(wb_wdata),
        .head(head), .pop(pop)
    );

    wft_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .head(head), .pop(pop),
        .wb_raddr(wb_raddr), .wb_rdata(wb_rdata),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_entry_index(m_entry_index), .m_word_count(m_word_count),
        .m_tally_status(m_tally_status)
    );

endmodule
`default_nettype wire

@@ rtl/wft_ram.sv @@
// Generic simple dual-port RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module wft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ rtl/wft_front.sv @@
// Front end: splits the byte stream into words and queues finished words.
`timescale 1ns / 1ps
`default_nettype none
module wft_front (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [7:0]                s_text_byte,
    input  wire logic                      s_end_of_text,
    output logic                           wb_we,
    output logic [wft_pkg::WB_W-1:0]       wb_waddr,
    output logic [7:0]                     wb_wdata,
    output wft_pkg::word_desc_t            head,
    input  wire logic                      pop
);

    logic [wft_pkg::LEN_W-1:0] wlen_reg, wlen_next;
    logic                      bank_reg, bank_next;
    logic [1:0]                count_reg, count_next;
    logic                      rd_reg, rd_next;
    logic [wft_pkg::LEN_W-1:0] qlen_reg [2];

    logic                      acc, sep, keep, push;
    logic [wft_pkg::LEN_W-1:0] len_after, push_len;

    // Classify the incoming item.
    always_comb begin
        acc       = s_valid && s_ready;
        sep       = wft_pkg::is_separator(s_text_byte);
        keep      = !sep && (wlen_reg < wft_pkg::LEN_W'(wft_pkg::WORD_CHARS));
        len_after = keep ? wlen_reg + wft_pkg::LEN_W'(1) : wlen_reg;
        push      = acc && (sep ? (wlen_reg != '0) : s_end_of_text);
        push_len  = sep ? wlen_reg : len_after;
    end

    // Character write into the current bank of the word buffer.
    assign wb_we    = acc && keep;
    assign wb_wdata = s_text_byte;
    assign wb_waddr = (bank_reg ? wft_pkg::WB_W'(wft_pkg::WORD_CHARS) : '0) +
                      wft_pkg::WB_W'(wlen_reg);

    // Queue status; each bank holds at most one finished word.
    assign s_ready    = (count_reg != 2'd2);
    assign head.valid = (count_reg != 2'd0);
    assign head.bank  = rd_reg;
    assign head.len   = qlen_reg[rd_reg];

    always_comb begin
        wlen_next  = wlen_reg;
        bank_next  = bank_reg;
        count_next = count_reg;
        rd_next    = rd_reg;
        if (acc) begin
            wlen_next = push ? '0 : len_after;
        end
        if (push) begin
            bank_next = !bank_reg;
        end
        if (pop) begin
            rd_next = !rd_reg;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wlen_reg  <= '0;
            bank_reg  <= 1'b0;
            count_reg <= 2'd0;
            rd_reg    <= 1'b0;
        end else begin
            wlen_reg  <= wlen_next;
            bank_reg  <= bank_next;
            count_reg <= count_next;
            rd_reg    <= rd_next;
        end
    end

    // Word length of each queued bank.
    always_ff @(posedge aclk) begin
        if (push) begin
            qlen_reg[bank_reg] <= push_len;
        end
    end

endmodule
`default_nettype wire

@@ rtl/wft_back.sv @@
// Back end: searches the table for each word and counts or inserts it.
`timescale 1ns / 1ps
`default_nettype none
`include "word_frequency_tally_defines.svh"
module wft_back (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire wft_pkg::word_desc_t            head,
    output logic                                pop,
    output logic [wft_pkg::WB_W-1:0]            wb_raddr,
    input  wire logic [7:0]                     wb_rdata,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [wft_pkg::IDX_OUT_W-1:0]       m_entry_index,
    output logic [wft_pkg::COUNT_W-1:0]         m_word_count,
    output logic [1:0]                          m_tally_status
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_LREQ   = 10'b0000000010,
        S_LCHK   = 10'b0000000100,
        S_CREQ   = 10'b0000001000,
        S_CCHK   = 10'b0000010000,
        S_CNT_RD = 10'b0000100000,
        S_CNT_WR = 10'b0001000000,
        S_CP_RD  = 10'b0010000000,
        S_CP_WR  = 10'b0100000000,
        S_DONE   = 10'b1000000000
    } state_t;

    state_t                          state_reg, state_next;
    logic [wft_pkg::USED_W-1:0]      e_reg, e_next;
    logic [wft_pkg::CADDR_W-1:0]     base_reg, base_next;
    logic [wft_pkg::LEN_W-1:0]       i_reg, i_next;
    logic [wft_pkg::USED_W-1:0]      used_reg, used_next;
    logic [wft_pkg::CADDR_W-1:0]     ubase_reg, ubase_next;
    logic                            stopped_reg, stopped_next;
    logic                            m_valid_reg, m_valid_next;

    logic [wft_pkg::IDX_OUT_W-1:0]   res_idx_reg, res_idx_next;
    logic [wft_pkg::COUNT_W-1:0]     res_cnt_reg, res_cnt_next;
    wft_pkg::tally_status_t          res_st_reg, res_st_next;
    logic [wft_pkg::IDX_OUT_W-1:0]   out_idx_reg;
    logic [wft_pkg::COUNT_W-1:0]     out_cnt_reg;
    wft_pkg::tally_status_t          out_st_reg;

    logic [wft_pkg::CADDR_W-1:0]     ch_raddr, ch_waddr;
    logic [7:0]                      ch_rdata;
    logic                            ch_we;
    logic [wft_pkg::LEN_W-1:0]       len_rdata;
    logic                            len_we;
    logic [wft_pkg::COUNT_W-1:0]     cnt_rdata, cnt_wdata;
    logic                            cnt_we;
    logic [wft_pkg::EIDX_W-1:0]      cnt_waddr;
    logic                            out_load;

    localparam logic [wft_pkg::CADDR_W-1:0] ROW_STEP = wft_pkg::CADDR_W'(wft_pkg::WORD_CHARS);

    // Table memories: characters, lengths and counts.
    wft_ram #(.WIDTH(8), .DEPTH(wft_pkg::CH_DEPTH)) u_chars (
        .aclk(aclk), .we(ch_we), .waddr(ch_waddr), .wdata(wb_rdata),
        .raddr(ch_raddr), .rdata(ch_rdata)
    );
    wft_ram #(.WIDTH(wft_pkg::LEN_W), .DEPTH(wft_pkg::TABLE_ENTRIES)) u_lens (
        .aclk(aclk), .we(len_we), .waddr(used_reg[wft_pkg::EIDX_W-1:0]),
        .wdata(head.len), .raddr(e_reg[wft_pkg::EIDX_W-1:0]), .rdata(len_rdata)
    );
    wft_ram #(.WIDTH(wft_pkg::COUNT_W), .DEPTH(wft_pkg::TABLE_ENTRIES)) u_counts (
        .aclk(aclk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
        .raddr(e_reg[wft_pkg::EIDX_W-1:0]), .rdata(cnt_rdata)
    );

    // Read addresses follow the search registers directly.
    assign ch_raddr = base_reg + wft_pkg::CADDR_W'(i_reg);
    assign ch_waddr = ubase_reg + wft_pkg::CADDR_W'(i_reg);
    assign wb_raddr = (head.bank ? wft_pkg::WB_W'(wft_pkg::WORD_CHARS) : '0) +
                      wft_pkg::WB_W'(i_reg);

    // Search, count and insert sequencer.
    always_comb begin
        state_next   = state_reg;
        e_next       = e_reg;
        base_next    = base_reg;
        i_next       = i_reg;
        used_next    = used_reg;
        ubase_next   = ubase_reg;
        stopped_next = stopped_reg;
        res_idx_next = res_idx_reg;
        res_cnt_next = res_cnt_reg;
        res_st_next  = res_st_reg;
        ch_we        = 1'b0;
        len_we       = 1'b0;
        cnt_we       = 1'b0;
        cnt_waddr    = e_reg[wft_pkg::EIDX_W-1:0];
        cnt_wdata    = (cnt_rdata == wft_pkg::COUNT_MAX) ? cnt_rdata
                       : cnt_rdata + wft_pkg::COUNT_W'(1);
        out_load     = 1'b0;
        pop          = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (head.valid) begin
                    if (stopped_reg) begin
                        res_idx_next = '0;
                        res_cnt_next = '0;
                        res_st_next  = wft_pkg::ST_STOPPED;
                        state_next   = S_DONE;
                    end else begin
                        e_next     = '0;
                        base_next  = '0;
                        state_next = S_LREQ;
                    end
                end
            end
            S_LREQ: begin
                if (e_reg == used_reg) begin
                    i_next     = '0;
                    state_next = S_CP_RD;
                end else begin
                    state_next = S_LCHK;
                end
            end
            S_LCHK: begin
                if (len_rdata == head.len) begin
                    i_next     = '0;
                    state_next = S_CREQ;
                end else begin
                    e_next     = e_reg + wft_pkg::USED_W'(1);
                    base_next  = base_reg + ROW_STEP;
                    state_next = S_LREQ;
                end
            end
            S_CREQ: begin
                state_next = S_CCHK;
            end
            S_CCHK: begin
                if (ch_rdata != wb_rdata) begin
                    e_next     = e_reg + wft_pkg::USED_W'(1);
                    base_next  = base_reg + ROW_STEP;
                    state_next = S_LREQ;
                end else if (i_reg == head.len - wft_pkg::LEN_W'(1)) begin
                    state_next = S_CNT_RD;
                end else begin
                    i_next     = i_reg + wft_pkg::LEN_W'(1);
                    state_next = S_CREQ;
                end
            end
            S_CNT_RD: begin
                state_next = S_CNT_WR;
            end
            S_CNT_WR: begin
                cnt_we       = 1'b1;
                res_idx_next = wft_pkg::IDX_OUT_W'(e_reg);
                res_cnt_next = cnt_wdata;
                res_st_next  = wft_pkg::ST_COUNTED;
                state_next   = S_DONE;
            end
            S_CP_RD: begin
                state_next = S_CP_WR;
            end
            S_CP_WR: begin
                ch_we = 1'b1;
                if (i_reg == head.len - wft_pkg::LEN_W'(1)) begin
                    // Last character copied: record length and first count.
                    len_we       = 1'b1;
                    cnt_we       = 1'b1;
                    cnt_waddr    = used_reg[wft_pkg::EIDX_W-1:0];
                    cnt_wdata    = wft_pkg::COUNT_W'(1);
                    res_idx_next = wft_pkg::IDX_OUT_W'(used_reg);
                    res_cnt_next = wft_pkg::COUNT_W'(1);
                    res_st_next  = wft_pkg::ST_INSERTED;
                    used_next    = used_reg + wft_pkg::USED_W'(1);
                    ubase_next   = ubase_reg + ROW_STEP;
                    stopped_next = (used_next == wft_pkg::USED_W'(wft_pkg::TABLE_ENTRIES));
                    state_next   = S_DONE;
                end else begin
                    i_next     = i_reg + wft_pkg::LEN_W'(1);
                    state_next = S_CP_RD;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    pop        = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Output register: S_DONE waits while it holds a result not yet taken.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            used_reg    <= '0;
            ubase_reg   <= '0;
            stopped_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            ubase_reg   <= ubase_next;
            stopped_reg <= stopped_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Search counters and result payload.
    always_ff @(posedge aclk) begin
        e_reg       <= e_next;
        base_reg    <= base_next;
        i_reg       <= i_next;
        res_idx_reg <= res_idx_next;
        res_cnt_reg <= res_cnt_next;
        res_st_reg  <= res_st_next;
        if (out_load) begin
            out_idx_reg <= res_idx_reg;
            out_cnt_reg <= res_cnt_reg;
            out_st_reg  <= res_st_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_entry_index  = out_idx_reg;
    assign m_word_count   = out_cnt_reg;
    assign m_tally_status = out_st_reg;

    // The table never holds more entries than it has rows.
    `WFT_ASSERT_NOW(a_used_bound, 1'b1, used_reg <= wft_pkg::USED_W'(wft_pkg::TABLE_ENTRIES))
    // Once counting stops it stays stopped.
    `WFT_ASSERT_NEXT(a_stop_sticky, stopped_reg, stopped_reg)
    // A word leaves the queue only when one is there.
    `WFT_ASSERT_NOW(a_pop_valid, pop, head.valid)
    // The search never runs past the used entries.
    `WFT_ASSERT_NOW(a_search_bound, state_reg != S_IDLE && state_reg != S_DONE, e_reg <= used_reg)

endmodule
`default_nettype wire
